>>> rtl/tsw_pkg.sv
// Shared types, widths and constants for the tube saturation waveshaper.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package tsw_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int MAX_POWER_DEF   = 10;

  localparam int XW         = 40;        // internal Q.29 working width
  localparam int MW         = 34;        // multiplier operand width
  localparam int PRW        = 2 * MW;    // product width
  localparam int DIV_W      = 36;        // divider dividend magnitude width
  localparam int RT_W       = 32;        // root width, radicand is twice this
  localparam int QF         = 29;
  localparam int HW         = 32;        // history register width
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int PAD_W      = 17;
  localparam int PF_W       = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_PAD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_RATE    = 2'd2;

  localparam logic [PAD_W-1:0] PAD_RESET = 17'd65536;
  localparam logic [PF_W-1:0]  PF_RESET  = 4'd10;

  localparam logic signed [XW-1:0] Q_ONE    = 40'sd536870912;
  localparam logic signed [XW-1:0] CLIP_052 = 40'sd279172874;
  localparam logic signed [MW-1:0] GAIN_RESCALE = 34'sd1032444062;

  typedef enum logic [5:0] {
    OP_NONE, OP_LOAD, OP_PAD_MUL, OP_PAD_WB, OP_AVG1, OP_CLAMP1,
    OP_DIVX, OP_DIVX_WB, OP_SQD, OP_SQD_WB, OP_MUL_DD, OP_T_WB,
    OP_MUL_TSH, OP_D_WB, OP_MUL_DP, OP_X_WB, OP_MUL_FM, OP_F_WB,
    OP_DIVF, OP_DIVF_WB, OP_DIVP, OP_DIVP_WB, OP_AVG2, OP_SLEW,
    OP_SQS, OP_SQS_WB, OP_MUL_XX, OP_MUL_TSL, OP_DIVT, OP_DIVT_WB,
    OP_CLAMP2, OP_MUL_G, OP_OUT
  } dp_op_t;

  typedef enum logic [5:0] {
    S_IDLE, S_PAD_MUL, S_PAD_WB, S_AVG1, S_CLAMP1,
    S_DIVX, S_DIVX_W, S_DIVX_WB, S_SQD, S_SQD_W, S_SQD_WB,
    S_MUL_DD, S_T1_WB, S_MUL_TSH, S_D_WB, S_MUL_DP, S_X_WB,
    S_MUL_FM, S_F_WB, S_DIVF, S_DIVF_W, S_DIVF_WB, S_DIVP, S_DIVP_W,
    S_DIVP_WB, S_AVG2, S_SLEW, S_SQS, S_SQS_W, S_SQS_WB, S_MUL_XX,
    S_T2_WB, S_MUL_TSL, S_DIVT, S_DIVT_W, S_DIVT_WB, S_CLAMP2,
    S_MUL_G, S_OUT
  } state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic pow_last;
    logic out_hold;
  } dp_stat_t;

  function automatic logic signed [XW-1:0] abs_x(input logic signed [XW-1:0] v);
    return v[XW-1] ? -v : v;
  endfunction

endpackage

>>> rtl/tsw_div.sv
// Shared restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on tsw_pkg.
`timescale 1ns / 1ps

module tsw_div #(
  parameter int PW = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [tsw_pkg::XW-1:0] dividend,
  input  logic [PW-1:0]                divisor,
  output logic signed [tsw_pkg::XW-1:0] quotient,
  output logic                         done
);
  import tsw_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              neg_r, neg_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [PW-1:0]     rem_r, rem_nxt;
  logic [PW-1:0]     dsr_r, dsr_nxt;
  logic [PW:0]       rem_sh, rem_diff;
  logic              ge;
  logic signed [XW-1:0] mag_in, quo_ext;

  assign mag_in   = abs_x(dividend);
  assign rem_sh   = {rem_r, quo_r[DIV_W-1]};
  assign rem_diff = rem_sh - {1'b0, dsr_r};
  assign ge       = rem_sh >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      neg_nxt  = dividend[XW-1];
      cnt_nxt  = '0;
      quo_nxt  = mag_in[DIV_W-1:0];
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_diff[PW-1:0] : rem_sh[PW-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quo_ext  = {{(XW-DIV_W){1'b0}}, quo_r};
  assign quotient = neg_r ? -quo_ext : quo_ext;
  assign done     = done_r;

endmodule

>>> rtl/tsw_sqrt.sv
// Bit-serial floor integer square root, one root bit per cycle.
// Depends on tsw_pkg.
`timescale 1ns / 1ps

module tsw_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [2*tsw_pkg::RT_W-1:0]  radicand,
  output logic [tsw_pkg::RT_W-1:0]    root,
  output logic                        done
);
  import tsw_pkg::*;

  localparam int CW = $clog2(RT_W);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [2*RT_W-1:0]  rad_r, rad_nxt;
  logic [RT_W+1:0]    rem_r, rem_nxt;
  logic [RT_W-1:0]    root_r, root_nxt;
  logic [RT_W+2:0]    rem_sh, trial, rem_diff;
  logic               ge;

  assign rem_sh   = {rem_r[RT_W:0], rad_r[2*RT_W-1 -: 2]};
  assign trial    = {1'b0, root_r, 2'b01};
  assign rem_diff = rem_sh - trial;
  assign ge       = rem_sh >= trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? rem_diff[RT_W+1:0] : rem_sh[RT_W+1:0];
      root_nxt = {root_r[RT_W-2:0], ge};
      rad_nxt  = {rad_r[2*RT_W-3:0], 2'b00};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CW'(RT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root = root_r;
  assign done = done_r;

endmodule

>>> rtl/tsw_datapath.sv
// Datapath: configuration, history and working registers, shared multiplier,
// divider and root units. Depends on tsw_pkg, tsw_div and tsw_sqrt.
`timescale 1ns / 1ps

module tsw_datapath #(
  parameter int SAMPLE_BITS = tsw_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_POWER   = tsw_pkg::MAX_POWER_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tsw_pkg::dp_cmd_t                  cmd,
  output tsw_pkg::dp_stat_t                 stat,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]     out_sample,
  input  logic                              cfg_we,
  input  logic [tsw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsw_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tsw_pkg::*;

  localparam int PW  = $clog2(MAX_POWER + 2);
  localparam int LSH = (SAMPLE_BITS <= 30) ? (30 - SAMPLE_BITS) : 0;
  localparam int RSH = (SAMPLE_BITS > 30) ? (SAMPLE_BITS - 30) : 0;
  localparam logic signed [XW-1:0] SAT_HI = (XW'(1) <<< (SAMPLE_BITS - 1)) - XW'(1);
  localparam logic signed [XW-1:0] SAT_LO = -(XW'(1) <<< (SAMPLE_BITS - 1));

  logic [PAD_W-1:0] pad_r, pad_nxt;
  logic [PF_W-1:0]  pf_r, pf_nxt;
  logic             hr_r, hr_nxt;

  logic [HW-1:0] hist_pre_r, hist_pre_nxt;
  logic [HW-1:0] hist_post_r, hist_post_nxt;
  logic [HW-1:0] hist_slew_r, hist_slew_nxt;

  logic signed [XW-1:0]  x_r, x_nxt, d_r, d_nxt, t_r, t_nxt, sh_r, sh_nxt;
  logic signed [XW-1:0]  f_r, f_nxt, m_r, m_nxt, slew_r, slew_nxt;
  logic signed [PRW-1:0] prod_r, prod_nxt;
  logic [PW-1:0]         p_r, p_nxt, cnt_r, cnt_nxt, p_eff;
  logic signed [SAMPLE_BITS-1:0] out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic signed [MW-1:0]  mul_a, mul_b;
  logic signed [PRW-1:0] prod_s16, prod_s29, prod_s31;
  logic signed [XW-1:0]  in_ext, in_x, abs_d, abs_slew, root_x, y, ysh;
  logic signed [XW-1:0]  h_pre, h_post, h_slew, abs_prod, abs_xr;
  logic signed [XW:0]    sum_pre, sum_post, sum_slew;

  logic                  div_start, sq_start;
  logic signed [XW-1:0]  div_dividend, div_q;
  logic [PW-1:0]         div_divisor;
  logic [2*RT_W-1:0]     sq_rad;
  logic [RT_W-1:0]       sq_root;
  logic                  div_done, sq_done;

  tsw_div #(.PW(PW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .done     (div_done)
  );

  tsw_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_rad),
    .root     (sq_root),
    .done     (sq_done)
  );

  // clamp the exponent into 1..MAX_POWER
  always_comb begin
    if (pf_r == '0) begin
      p_eff = PW'(1);
    end else if (int'(pf_r) > MAX_POWER) begin
      p_eff = PW'(MAX_POWER);
    end else begin
      p_eff = PW'(pf_r);
    end
  end

  assign in_ext   = {{(XW-SAMPLE_BITS){in_sample[SAMPLE_BITS-1]}}, in_sample};
  assign in_x     = (in_ext <<< LSH) >>> RSH;
  assign prod_s16 = prod_r >>> 16;
  assign prod_s29 = prod_r >>> QF;
  assign prod_s31 = prod_r >>> (QF + 2);
  assign abs_d    = abs_x(d_r);
  assign abs_slew = abs_x(slew_r);
  assign abs_prod = abs_x(prod_r[XW-1:0]);
  assign abs_xr   = abs_x(x_r);
  assign root_x   = {{(XW-RT_W){1'b0}}, sq_root};
  assign h_pre    = {{(XW-HW){hist_pre_r[HW-1]}}, hist_pre_r};
  assign h_post   = {{(XW-HW){hist_post_r[HW-1]}}, hist_post_r};
  assign h_slew   = {{(XW-HW){hist_slew_r[HW-1]}}, hist_slew_r};
  assign sum_pre  = {x_r[XW-1], x_r} + {h_pre[XW-1], h_pre};
  assign sum_post = {x_r[XW-1], x_r} + {h_post[XW-1], h_post};
  assign sum_slew = {x_r[XW-1], x_r} + {h_slew[XW-1], h_slew};
  assign y        = prod_s29[XW-1:0];
  assign ysh      = (y >>> LSH) <<< RSH;

  // multiplier operand select
  always_comb begin
    mul_a = x_r[MW-1:0];
    mul_b = x_r[MW-1:0];
    case (cmd.op)
      OP_PAD_MUL: mul_b = {{(MW-PAD_W){1'b0}}, pad_r};
      OP_MUL_DD:  begin mul_a = d_r[MW-1:0]; mul_b = abs_d[MW-1:0]; end
      OP_MUL_TSH: begin mul_a = t_r[MW-1:0]; mul_b = sh_r[MW-1:0]; end
      OP_MUL_DP:  begin mul_a = d_r[MW-1:0]; mul_b = {{(MW-PW){1'b0}}, p_r}; end
      OP_MUL_FM:  begin mul_a = f_r[MW-1:0]; mul_b = m_r[MW-1:0]; end
      OP_MUL_XX:  mul_b = abs_xr[MW-1:0];
      OP_MUL_TSL: begin mul_a = t_r[MW-1:0]; mul_b = sh_r[MW-1:0]; end
      OP_MUL_G:   mul_b = GAIN_RESCALE;
      default:    mul_b = x_r[MW-1:0];
    endcase
  end

  // divider and root unit launch
  always_comb begin
    div_start    = 1'b0;
    div_dividend = x_r;
    div_divisor  = p_r;
    sq_start     = 1'b0;
    sq_rad       = {{(2*RT_W-XW){1'b0}}, abs_d} << QF;
    case (cmd.op)
      OP_DIVX: div_start = 1'b1;
      OP_DIVF: begin
        div_start    = 1'b1;
        div_dividend = x_r[XW-1] ? -f_r : f_r;
        div_divisor  = p_r + 1'b1;
      end
      OP_DIVP: div_start = 1'b1;
      OP_DIVT: begin
        div_start    = 1'b1;
        div_dividend = prod_s29[XW-1:0];
        div_divisor  = p_r + 1'b1;
      end
      OP_SQD:  sq_start = 1'b1;
      OP_SQS:  begin
        sq_start = 1'b1;
        sq_rad   = {{(2*RT_W-XW){1'b0}}, abs_slew} << QF;
      end
      default: div_start = 1'b0;
    endcase
  end

  always_comb begin
    pad_nxt       = pad_r;
    pf_nxt        = pf_r;
    hr_nxt        = hr_r;
    hist_pre_nxt  = hist_pre_r;
    hist_post_nxt = hist_post_r;
    hist_slew_nxt = hist_slew_r;
    x_nxt         = x_r;
    d_nxt         = d_r;
    t_nxt         = t_r;
    sh_nxt        = sh_r;
    f_nxt         = f_r;
    m_nxt         = m_r;
    slew_nxt      = slew_r;
    prod_nxt      = prod_r;
    p_nxt         = p_r;
    cnt_nxt       = cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_index)
        CFG_INPUT_PAD:    pad_nxt = cfg_data[PAD_W-1:0];
        CFG_POWER_FACTOR: pf_nxt  = cfg_data[PF_W-1:0];
        CFG_HIGH_RATE:    hr_nxt  = cfg_data[0];
        default:          pad_nxt = pad_r;
      endcase
    end

    case (cmd.op)
      OP_LOAD: begin
        x_nxt = in_x;
        p_nxt = p_eff;
      end
      OP_PAD_MUL, OP_MUL_DD, OP_MUL_TSH, OP_MUL_DP, OP_MUL_FM,
      OP_MUL_XX, OP_MUL_TSL, OP_MUL_G: prod_nxt = mul_a * mul_b;
      OP_PAD_WB: if (!pad_r[PAD_W-1]) x_nxt = prod_s16[XW-1:0];
      OP_AVG1: if (hr_r) begin
        x_nxt        = sum_pre[XW:1];
        hist_pre_nxt = x_r[HW-1:0];
      end
      OP_CLAMP1: begin
        if (x_r > Q_ONE) x_nxt = Q_ONE;
        else if (x_r < -Q_ONE) x_nxt = -Q_ONE;
      end
      OP_DIVX_WB: d_nxt = div_q;
      OP_SQD_WB:  sh_nxt = d_r[XW-1] ? Q_ONE + root_x : Q_ONE - root_x;
      OP_T_WB:    t_nxt = prod_s29[XW-1:0];
      OP_D_WB:    d_nxt = d_r - prod_s31[XW-1:0];
      OP_X_WB: begin
        x_nxt   = prod_r[XW-1:0];
        m_nxt   = abs_prod;
        f_nxt   = abs_prod;
        cnt_nxt = '0;
      end
      OP_F_WB: begin
        f_nxt   = prod_s29[XW-1:0];
        cnt_nxt = cnt_r + 1'b1;
      end
      OP_DIVF_WB: x_nxt = x_r - div_q;
      OP_DIVP_WB: x_nxt = x_r + div_q;
      OP_AVG2: if (hr_r) begin
        x_nxt         = sum_post[XW:1];
        hist_post_nxt = x_r[HW-1:0];
      end
      OP_SLEW: begin
        slew_nxt      = h_slew - x_r;
        hist_slew_nxt = x_r[HW-1:0];
        if (hr_r) x_nxt = sum_slew[XW:1];
      end
      OP_SQS_WB: sh_nxt = (slew_r > 0) ? Q_ONE + (root_x >>> 1) : Q_ONE - (root_x >>> 1);
      OP_DIVT_WB: x_nxt = x_r - div_q;
      OP_CLAMP2: begin
        if (x_r > CLIP_052) x_nxt = CLIP_052;
        else if (x_r < -CLIP_052) x_nxt = -CLIP_052;
      end
      OP_OUT: begin
        if (ysh > SAT_HI) out_nxt = SAT_HI[SAMPLE_BITS-1:0];
        else if (ysh < SAT_LO) out_nxt = SAT_LO[SAMPLE_BITS-1:0];
        else out_nxt = ysh[SAMPLE_BITS-1:0];
        out_valid_nxt = 1'b1;
      end
      default: x_nxt = x_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_r       <= PAD_RESET;
      pf_r        <= PF_RESET;
      hr_r        <= 1'b0;
      hist_pre_r  <= '0;
      hist_post_r <= '0;
      hist_slew_r <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      pad_r       <= pad_nxt;
      pf_r        <= pf_nxt;
      hr_r        <= hr_nxt;
      hist_pre_r  <= hist_pre_nxt;
      hist_post_r <= hist_post_nxt;
      hist_slew_r <= hist_slew_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    x_r    <= x_nxt;
    d_r    <= d_nxt;
    t_r    <= t_nxt;
    sh_r   <= sh_nxt;
    f_r    <= f_nxt;
    m_r    <= m_nxt;
    slew_r <= slew_nxt;
    prod_r <= prod_nxt;
    p_r    <= p_nxt;
    out_r  <= out_nxt;
  end

  assign stat.div_done  = div_done;
  assign stat.sqrt_done = sq_done;
  assign stat.pow_last  = (cnt_r == p_r - 1'b1);
  assign stat.out_hold  = out_valid_r && !out_ready;
  assign out_valid      = out_valid_r;
  assign out_sample     = out_r;

endmodule

>>> rtl/tsw_ctrl.sv
// Controller: sequences the datapath through the shaping steps of one word.
// Depends on tsw_pkg.
`timescale 1ns / 1ps

module tsw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tsw_pkg::dp_stat_t stat,
  output tsw_pkg::dp_cmd_t  cmd
);
  import tsw_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_PAD_MUL;
      S_PAD_MUL: state_nxt = S_PAD_WB;
      S_PAD_WB:  state_nxt = S_AVG1;
      S_AVG1:    state_nxt = S_CLAMP1;
      S_CLAMP1:  state_nxt = S_DIVX;
      S_DIVX:    state_nxt = S_DIVX_W;
      S_DIVX_W:  if (stat.div_done) state_nxt = S_DIVX_WB;
      S_DIVX_WB: state_nxt = S_SQD;
      S_SQD:     state_nxt = S_SQD_W;
      S_SQD_W:   if (stat.sqrt_done) state_nxt = S_SQD_WB;
      S_SQD_WB:  state_nxt = S_MUL_DD;
      S_MUL_DD:  state_nxt = S_T1_WB;
      S_T1_WB:   state_nxt = S_MUL_TSH;
      S_MUL_TSH: state_nxt = S_D_WB;
      S_D_WB:    state_nxt = S_MUL_DP;
      S_MUL_DP:  state_nxt = S_X_WB;
      S_X_WB:    state_nxt = S_MUL_FM;
      S_MUL_FM:  state_nxt = S_F_WB;
      S_F_WB:    state_nxt = stat.pow_last ? S_DIVF : S_MUL_FM;
      S_DIVF:    state_nxt = S_DIVF_W;
      S_DIVF_W:  if (stat.div_done) state_nxt = S_DIVF_WB;
      S_DIVF_WB: state_nxt = S_DIVP;
      S_DIVP:    state_nxt = S_DIVP_W;
      S_DIVP_W:  if (stat.div_done) state_nxt = S_DIVP_WB;
      S_DIVP_WB: state_nxt = S_AVG2;
      S_AVG2:    state_nxt = S_SLEW;
      S_SLEW:    state_nxt = S_SQS;
      S_SQS:     state_nxt = S_SQS_W;
      S_SQS_W:   if (stat.sqrt_done) state_nxt = S_SQS_WB;
      S_SQS_WB:  state_nxt = S_MUL_XX;
      S_MUL_XX:  state_nxt = S_T2_WB;
      S_T2_WB:   state_nxt = S_MUL_TSL;
      S_MUL_TSL: state_nxt = S_DIVT;
      S_DIVT:    state_nxt = S_DIVT_W;
      S_DIVT_W:  if (stat.div_done) state_nxt = S_DIVT_WB;
      S_DIVT_WB: state_nxt = S_CLAMP2;
      S_CLAMP2:  state_nxt = S_MUL_G;
      S_MUL_G:   state_nxt = S_OUT;
      S_OUT:     if (!stat.out_hold) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == S_IDLE);
    cmd.op   = OP_NONE;
    case (state_r)
      S_IDLE:    if (in_valid) cmd.op = OP_LOAD;
      S_PAD_MUL: cmd.op = OP_PAD_MUL;
      S_PAD_WB:  cmd.op = OP_PAD_WB;
      S_AVG1:    cmd.op = OP_AVG1;
      S_CLAMP1:  cmd.op = OP_CLAMP1;
      S_DIVX:    cmd.op = OP_DIVX;
      S_DIVX_WB: cmd.op = OP_DIVX_WB;
      S_SQD:     cmd.op = OP_SQD;
      S_SQD_WB:  cmd.op = OP_SQD_WB;
      S_MUL_DD:  cmd.op = OP_MUL_DD;
      S_T1_WB:   cmd.op = OP_T_WB;
      S_MUL_TSH: cmd.op = OP_MUL_TSH;
      S_D_WB:    cmd.op = OP_D_WB;
      S_MUL_DP:  cmd.op = OP_MUL_DP;
      S_X_WB:    cmd.op = OP_X_WB;
      S_MUL_FM:  cmd.op = OP_MUL_FM;
      S_F_WB:    cmd.op = OP_F_WB;
      S_DIVF:    cmd.op = OP_DIVF;
      S_DIVF_WB: cmd.op = OP_DIVF_WB;
      S_DIVP:    cmd.op = OP_DIVP;
      S_DIVP_WB: cmd.op = OP_DIVP_WB;
      S_AVG2:    cmd.op = OP_AVG2;
      S_SLEW:    cmd.op = OP_SLEW;
      S_SQS:     cmd.op = OP_SQS;
      S_SQS_WB:  cmd.op = OP_SQS_WB;
      S_MUL_XX:  cmd.op = OP_MUL_XX;
      S_T2_WB:   cmd.op = OP_T_WB;
      S_MUL_TSL: cmd.op = OP_MUL_TSL;
      S_DIVT:    cmd.op = OP_DIVT;
      S_DIVT_WB: cmd.op = OP_DIVT_WB;
      S_CLAMP2:  cmd.op = OP_CLAMP2;
      S_MUL_G:   cmd.op = OP_MUL_G;
      S_OUT:     if (!stat.out_hold) cmd.op = OP_OUT;
      default:   cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/tube_saturation_waveshaper_unit.sv
// From acceptance to out_valid a word passes the shaping chain one controller state at a time,
// waiting on the shared divider (four uses) and the root unit (two uses) and looping the power step.
// The block takes no new word until the previous one is through; the next word is taken
// once the controller is idle, while the previous result may still wait in the output register.
// Reset (synchronous, rst_n low): registers return to pad unity, power 10, high rate off;
// the three history registers clear to zero.
`timescale 1ns / 1ps

module tube_saturation_waveshaper_unit #(
  parameter int SAMPLE_BITS = tsw_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_POWER   = tsw_pkg::MAX_POWER_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_BITS-1:0]  in_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_BITS-1:0]  out_sample,
  input  logic                           cfg_we,
  input  logic [tsw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tsw_pkg::*;

  // command from the controller, status back from the datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: one step of the shaping chain per state, waits on the units
  tsw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // working registers, multiplier, divider, root unit and output register
  tsw_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_POWER   (MAX_POWER)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

`ifndef ASSERT_OFF
  // a word in flight keeps the input closed
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again while a word is in flight");

  // divider and root unit never finish together
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.div_done && stat.sqrt_done))
    else $error("divider and root unit finished in the same cycle");

  // never overwrite a result still waiting downstream
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    stat.out_hold |-> cmd.op != OP_OUT)
    else $error("result written while output stalled");
`endif

endmodule
